// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL; bodies compile away under SYNTHESIS.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

// ----- rtl/core/wsof_pkg.sv -----
// Shared types and constants of the weighted sigma outlier flag.
// No dependencies.
`timescale 1ns / 1ps
package wsof_pkg;

  localparam int MaxNeighbours = 32;
  localparam int QueueDepth    = 4;
  localparam logic [15:0] SigmaReset = 16'd768;

  typedef enum logic [1:0] {
    StTooFew  = 2'd0,
    StKept    = 2'd1,
    StSpeckle = 2'd2,
    StDegen   = 2'd3
  } status_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sample_value;
    logic [15:0]        sample_weight;
    logic               group_last;
  } wsof_in_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] mean_value;
    logic [15:0]        stdev_value;
    logic [5:0]         neighbour_count;
  } wsof_out_t;

  // accumulated totals of one finished group
  typedef struct packed {
    logic signed [36:0] wsum;
    logic [52:0]        wsq_sum;
    logic [20:0]        wgt_sum;
    logic [36:0]        wgt_sq_sum;
    logic [5:0]         count;
    logic signed [15:0] centre;
  } wsof_snap_t;

endpackage

// ----- rtl/core/wsof_front.sv -----
// Front end: product pipeline and per-group accumulators, pushes group totals.
// Depends on wsof_pkg.
`timescale 1ns / 1ps
module wsof_front import wsof_pkg::*; #(
  parameter int MAX_NEIGHBOURS = MaxNeighbours,
  parameter int QUEUE_DEPTH    = QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  wsof_in_t                           in_data_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_level_i,
  output logic                               push_o,
  output wsof_snap_t                         snap_o
);

  localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

  logic accept;

  // stage 1: first products
  logic               s1_valid_q;
  logic               s1_cmd_q, s1_last_q;
  logic signed [15:0] s1_v_q;
  logic [15:0]        s1_w_q;
  logic signed [32:0] s1_vw_q;
  logic [30:0]        s1_vv_q;
  logic [31:0]        s1_ww_q;

  logic [16:0]        mag;
  logic [33:0]        vv_full;
  logic signed [32:0] vw;

  // stage 2: value^2 * weight
  logic               s2_valid_q;
  logic               s2_cmd_q, s2_last_q;
  logic signed [15:0] s2_v_q;
  logic [15:0]        s2_w_q;
  logic signed [32:0] s2_vw_q;
  logic [31:0]        s2_ww_q;
  logic [46:0]        s2_vvw_q;

  // accumulators
  logic signed [36:0] wsum_q, wsum_d, wsum_nx;
  logic [52:0]        wsq_q, wsq_d, wsq_nx;
  logic [20:0]        wgt_q, wgt_d, wgt_nx;
  logic [36:0]        wgt_sq_q, wgt_sq_d, wgt_sq_nx;
  logic [5:0]         cnt_q, cnt_d, cnt_nx;
  logic signed [15:0] centre_q, centre_d, centre_nx;

  logic [LvlW:0]      occ;

  // groups in flight count against queue room
  assign occ = {1'b0, q_level_i} + (LvlW+1)'(s1_valid_q & s1_last_q)
             + (LvlW+1)'(s2_valid_q & s2_last_q);
  assign in_stall_o = (occ >= (LvlW+1)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign mag     = in_data_i.sample_value[15] ? (~{1'b1, in_data_i.sample_value} + 17'd1)
                                              : {1'b0, in_data_i.sample_value};
  assign vv_full = {17'd0, mag} * {17'd0, mag};
  assign vw      = in_data_i.sample_value * $signed({1'b0, in_data_i.sample_weight});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wsum_q     <= '0;
      wsq_q      <= '0;
      wgt_q      <= '0;
      wgt_sq_q   <= '0;
      cnt_q      <= '0;
      centre_q   <= '0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      wsum_q     <= wsum_d;
      wsq_q      <= wsq_d;
      wgt_q      <= wgt_d;
      wgt_sq_q   <= wgt_sq_d;
      cnt_q      <= cnt_d;
      centre_q   <= centre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= in_data_i.cmd;
    s1_last_q <= in_data_i.group_last;
    s1_v_q    <= in_data_i.sample_value;
    s1_w_q    <= in_data_i.sample_weight;
    s1_vw_q   <= vw;
    s1_vv_q   <= vv_full[30:0];
    s1_ww_q   <= in_data_i.sample_weight * in_data_i.sample_weight;
    s2_cmd_q  <= s1_cmd_q;
    s2_last_q <= s1_last_q;
    s2_v_q    <= s1_v_q;
    s2_w_q    <= s1_w_q;
    s2_vw_q   <= s1_vw_q;
    s2_ww_q   <= s1_ww_q;
    s2_vvw_q  <= {16'd0, s1_vv_q} * {31'd0, s1_w_q};
  end

  always_comb begin
    wsum_nx   = wsum_q;
    wsq_nx    = wsq_q;
    wgt_nx    = wgt_q;
    wgt_sq_nx = wgt_sq_q;
    cnt_nx    = cnt_q;
    centre_nx = centre_q;
    if (s2_valid_q) begin
      if (s2_cmd_q) begin
        centre_nx = s2_v_q;
      end else if (cnt_q < 6'(MAX_NEIGHBOURS)) begin
        wsum_nx   = wsum_q + {{4{s2_vw_q[32]}}, s2_vw_q};
        wsq_nx    = wsq_q + {6'd0, s2_vvw_q};
        wgt_nx    = wgt_q + {5'd0, s2_w_q};
        wgt_sq_nx = wgt_sq_q + {5'd0, s2_ww_q};
        cnt_nx    = cnt_q + 6'd1;
      end
    end
    push_o            = s2_valid_q && s2_last_q;
    snap_o.wsum       = wsum_nx;
    snap_o.wsq_sum    = wsq_nx;
    snap_o.wgt_sum    = wgt_nx;
    snap_o.wgt_sq_sum = wgt_sq_nx;
    snap_o.count      = cnt_nx;
    snap_o.centre     = centre_nx;
    if (push_o) begin
      wsum_d   = '0;
      wsq_d    = '0;
      wgt_d    = '0;
      wgt_sq_d = '0;
      cnt_d    = '0;
      centre_d = '0;
    end else begin
      wsum_d   = wsum_nx;
      wsq_d    = wsq_nx;
      wgt_d    = wgt_nx;
      wgt_sq_d = wgt_sq_nx;
      cnt_d    = cnt_nx;
      centre_d = centre_nx;
    end
  end

endmodule

// ----- rtl/core/wsof_queue.sv -----
// Small FIFO of group totals between front and back end.
// Depends on wsof_pkg.
`timescale 1ns / 1ps
module wsof_queue import wsof_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  wsof_snap_t                   snap_i,
  input  logic                         pop_i,
  output wsof_snap_t                   head_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LvlW = $clog2(DEPTH + 1);

  wsof_snap_t       slot_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [LvlW-1:0]  lvl_q;
  logic             do_push, do_pop;

  assign empty_o = (lvl_q == '0);
  assign full_o  = (lvl_q == LvlW'(DEPTH));
  assign level_o = lvl_q;
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        lvl_q <= lvl_q + LvlW'(1);
      end else if (do_pop && !do_push) begin
        lvl_q <= lvl_q - LvlW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= snap_i;
    end
  end

endmodule

// ----- rtl/core/wsof_back.sv -----
// Back end: mean division, variance by shift-add multiply and restoring
// divide, integer square root, speckle test, output register. Depends on wsof_pkg.
`timescale 1ns / 1ps
module wsof_back import wsof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] sigma_i,
  input  logic        q_empty_i,
  input  wsof_snap_t  head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wsof_out_t   out_data_o
);

  typedef enum logic [9:0] {
    Idle = 10'b0000000001,
    Load = 10'b0000000010,
    Mean = 10'b0000000100,
    MulA = 10'b0000001000,
    MulB = 10'b0000010000,
    VSub = 10'b0000100000,
    VChk = 10'b0001000000,
    VDiv = 10'b0010000000,
    Sqrt = 10'b0100000000,
    Fin  = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [5:0]         step_q, step_d;
  logic               neg_q, neg_d;
  logic [36:0]        smag_q, smag_d;
  logic [52:0]        s2_q, s2_d;
  logic [20:0]        w_q, w_d;
  logic [36:0]        w2_q, w2_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [15:0] centre_q, centre_d;
  logic [42:0]        den_q, den_d;
  logic [42:0]        rem_q, rem_d;
  logic [73:0]        sh_q, sh_d;
  logic [36:0]        mpl_q, mpl_d;
  logic [73:0]        acc_q, acc_d;
  logic [73:0]        a_q, a_d;
  logic [31:0]        sqn_q, sqn_d;
  logic [31:0]        sqr_q, sqr_d;
  logic [30:0]        sqb_q, sqb_d;
  status_e            status_q, status_d;
  logic signed [15:0] mean_q, mean_d;
  logic [15:0]        stdev_q, stdev_d;
  logic               out_valid_q, out_valid_d;
  wsof_out_t          out_q, out_d;

  logic [41:0]        wsq;
  logic               den_le0;
  logic [22:0]        mr, mdvs;
  logic               mge;
  logic [38:0]        quo;
  logic [42:0]        vr;
  logic               vge;
  logic [31:0]        rb;
  logic signed [16:0] diff;
  logic [16:0]        adiff;
  logic [31:0]        thr;
  logic               take;

  assign wsq     = w_q * w_q;
  assign den_le0 = den_q[42] || (den_q == '0);
  assign mr      = {rem_q[21:0], sh_q[38]};
  assign mdvs    = {1'b0, w_q, 1'b0};
  assign mge     = (mr >= mdvs);
  assign vr      = {rem_q[41:0], sh_q[31]};
  assign vge     = (vr >= {1'b0, den_q[41:0]});
  assign rb      = sqr_q + {1'b0, sqb_q};
  assign diff    = {centre_q[15], centre_q} - {mean_q[15], mean_q};
  assign adiff   = diff[16] ? 17'(-diff) : 17'(diff);
  assign thr     = sigma_i * stdev_q;
  assign take    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    neg_d       = neg_q;
    smag_d      = smag_q;
    s2_d        = s2_q;
    w_d         = w_q;
    w2_d        = w2_q;
    cnt_d       = cnt_q;
    centre_d    = centre_q;
    den_d       = den_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    mpl_d       = mpl_q;
    acc_d       = acc_q;
    a_d         = a_q;
    sqn_d       = sqn_q;
    sqr_d       = sqr_q;
    sqb_d       = sqb_q;
    status_d    = status_q;
    mean_d      = mean_q;
    stdev_d     = stdev_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    quo         = '0;

    unique case (state_q)
      Idle: begin
        if (!q_empty_i) begin
          pop_o    = 1'b1;
          neg_d    = head_i.wsum[36];
          smag_d   = head_i.wsum[36] ? 37'(-head_i.wsum) : 37'(head_i.wsum);
          s2_d     = head_i.wsq_sum;
          w_d      = head_i.wgt_sum;
          w2_d     = head_i.wgt_sq_sum;
          cnt_d    = head_i.count;
          centre_d = head_i.centre;
          state_d  = Load;
        end
      end
      Load: begin
        den_d   = {1'b0, wsq} - {6'd0, w2_q};
        mean_d  = '0;
        stdev_d = '0;
        if (cnt_q < 6'd2) begin
          status_d = StTooFew;
          state_d  = Fin;
        end else begin
          sh_d    = {35'd0, {smag_q, 1'b0} + {18'd0, w_q}};
          rem_d   = '0;
          step_d  = 6'd39;
          state_d = Mean;
        end
      end
      Mean: begin
        rem_d  = {20'd0, mge ? (mr - mdvs) : mr};
        sh_d   = {35'd0, sh_q[37:0], mge};
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) begin
          quo = sh_d[38:0];
          if (w_q == '0) begin
            mean_d = '0;
          end else if (neg_q) begin
            mean_d = (quo > 39'd32768) ? -16'sd32768 : 16'(-quo);
          end else begin
            mean_d = (quo > 39'd32767) ? 16'sd32767 : 16'(quo);
          end
          if (den_le0) begin
            status_d = StDegen;
            state_d  = Fin;
          end else begin
            status_d = StKept;
            sh_d     = {21'd0, s2_q};
            mpl_d    = {16'd0, w_q};
            acc_d    = '0;
            step_d   = 6'd21;
            state_d  = MulA;
          end
        end
      end
      MulA, MulB: begin
        acc_d  = acc_q + (mpl_q[0] ? sh_q : '0);
        sh_d   = {sh_q[72:0], 1'b0};
        mpl_d  = {1'b0, mpl_q[36:1]};
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) begin
          if (state_q == MulA) begin
            a_d     = acc_d;
            sh_d    = {37'd0, smag_q};
            mpl_d   = smag_q;
            acc_d   = '0;
            step_d  = 6'd37;
            state_d = MulB;
          end else begin
            state_d = VSub;
          end
        end
      end
      VSub: begin
        sh_d    = (a_q >= acc_q) ? (a_q - acc_q) : '0;
        state_d = VChk;
      end
      VChk: begin
        // quotient of 2^32 or more saturates
        if (sh_q >= {den_q[41:0], 32'd0}) begin
          sqn_d   = '1;
          sqr_d   = '0;
          sqb_d   = 31'h4000_0000;
          step_d  = 6'd16;
          state_d = Sqrt;
        end else begin
          rem_d   = {1'b0, sh_q[73:32]};
          step_d  = 6'd32;
          state_d = VDiv;
        end
      end
      VDiv: begin
        rem_d  = vge ? (vr - {1'b0, den_q[41:0]}) : vr;
        sh_d   = {sh_q[73:32], sh_q[30:0], vge};
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) begin
          sqn_d   = sh_d[31:0];
          sqr_d   = '0;
          sqb_d   = 31'h4000_0000;
          step_d  = 6'd16;
          state_d = Sqrt;
        end
      end
      Sqrt: begin
        if (sqn_q >= rb) begin
          sqn_d = sqn_q - rb;
          sqr_d = {1'b0, sqr_q[31:1]} + {1'b0, sqb_q};
        end else begin
          sqr_d = {1'b0, sqr_q[31:1]};
        end
        sqb_d  = {2'b00, sqb_q[30:2]};
        step_d = step_q - 6'd1;
        if (step_q == 6'd1) begin
          stdev_d = sqr_d[15:0];
          state_d = Fin;
        end
      end
      Fin: begin
        if (take) begin
          out_d.status = status_q;
          if (status_q == StKept) begin
            out_d.status = ({15'd0, adiff} << 8 > thr) ? StSpeckle : StKept;
          end
          out_d.mean_value      = mean_q;
          out_d.stdev_value     = stdev_q;
          out_d.neighbour_count = cnt_q;
          out_valid_d           = 1'b1;
          state_d               = Idle;
        end
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    neg_q    <= neg_d;
    smag_q   <= smag_d;
    s2_q     <= s2_d;
    w_q      <= w_d;
    w2_q     <= w2_d;
    cnt_q    <= cnt_d;
    centre_q <= centre_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    sh_q     <= sh_d;
    mpl_q    <= mpl_d;
    acc_q    <= acc_d;
    a_q      <= a_d;
    sqn_q    <= sqn_d;
    sqr_q    <= sqr_d;
    sqb_q    <= sqb_d;
    status_q <= status_d;
    mean_q   <= mean_d;
    stdev_q  <= stdev_d;
    out_q    <= out_d;
  end

endmodule

// ----- rtl/core/weighted_sigma_outlier_flag.sv -----
// Channel   Dir  Handshake              Payload
// in        in   in_valid_i/in_stall_o    wsof_in_t (cmd, value, weight, last)
// out       out  out_valid_o/out_stall_i  wsof_out_t (status, mean, stdev, count)
// cfg       in   cfg_we_i                 cfg_wdata_i -> sigma threshold
// Neighbour and centre items enter one per cycle while in_stall_o is low; it
// rises once queued groups plus group ends in the two-stage product pipeline
// reach the queue depth. Each group then passes the back end's bit-serial
// units in order: mean divide, two shift-add multiplies, variance divide,
// square root. Stall on out holds the result; the back end starts the
// next group meanwhile. Reset clears accumulators, queue and sets sigma 3.0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module weighted_sigma_outlier_flag import wsof_pkg::*; #(
  parameter int MAX_NEIGHBOURS = MaxNeighbours,
  parameter int QUEUE_DEPTH    = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  wsof_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wsof_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int LvlW = $clog2(QUEUE_DEPTH + 1);

  logic [15:0]     sigma_q;
  logic            push, pop, q_empty, q_full;
  logic [LvlW-1:0] q_level;
  wsof_snap_t      snap, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SigmaReset;
    end else if (cfg_we_i) begin
      sigma_q <= cfg_wdata_i;
    end
  end

  wsof_front #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_level_i  (q_level),
    .push_o     (push),
    .snap_o     (snap)
  );

  wsof_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .snap_i  (snap),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full),
    .level_o (q_level)
  );

  wsof_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sigma_i     (sigma_q),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push && q_full && !pop, "group pushed into full queue")
  `ASSERT_HOLDS(a_too_few_zero, clk_i, rst_ni, out_valid_o && out_data_o.status == StTooFew |-> out_data_o.mean_value == '0 && out_data_o.stdev_value == '0, "too-few result not zeroed")
  `ASSERT_HOLDS(a_degen_stdev, clk_i, rst_ni, out_valid_o && out_data_o.status == StDegen |-> out_data_o.stdev_value == '0, "degenerate result with nonzero stdev")
  `ASSERT_HOLDS(a_count_max, clk_i, rst_ni, out_valid_o |-> out_data_o.neighbour_count <= 6'(MAX_NEIGHBOURS), "neighbour count above limit")

endmodule
